@@ src/capt_pkg.sv @@
// ----------------------------------------------------------------------------
// capt_pkg
// Shared constants, character codes and types of the call argument tracker.
// ----------------------------------------------------------------------------
package capt_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned COMMA_BITS  = 8;
  localparam int unsigned CHAR_W      = 16;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned CMP_W       = (COMMA_BITS > COUNT_W) ? COMMA_BITS : COUNT_W;

  localparam logic [COMMA_BITS-1:0] COMMA_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_HASH   = 16'h0023;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_LF     = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_PARA   = 16'h2029;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 16'h0028;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 16'h0029;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 16'h005D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 16'h002C;

  typedef enum logic [1:0] {
    MODE_CODE,
    MODE_COMMENT,
    MODE_SQ,
    MODE_DQ
  } lex_mode_e;

  typedef enum logic [1:0] {
    KIND_PAREN,
    KIND_SQUARE,
    KIND_CURLY
  } bracket_kind_e;

  typedef struct packed {
    logic          push;
    logic          close;
    logic          comma;
    bracket_kind_e kind;
  } stack_op_t;

  typedef struct packed {
    logic open;
    logic match;
  } cell_link_t;

endpackage

@@ src/capt_char_if.sv @@
// ----------------------------------------------------------------------------
// capt_char_if
// Character channel: one UTF-16 code unit per beat.
// ----------------------------------------------------------------------------
interface capt_char_if
  import capt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

@@ src/capt_result_if.sv @@
// ----------------------------------------------------------------------------
// capt_result_if
// Result channel: argument position report, one beat per character.
// ----------------------------------------------------------------------------
interface capt_result_if
  import capt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               index_valid;
  logic [INDEX_W-1:0] argument_index;
  logic               stack_overflowed;

  modport source (output valid, output index_valid, output argument_index,
                  output stack_overflowed, input ready);
  modport sink   (input valid, input index_valid, input argument_index,
                  input stack_overflowed, output ready);
endinterface

@@ src/capt_lexer.sv @@
// ----------------------------------------------------------------------------
// capt_lexer
// Comment and string skipper; turns characters into stack operations.
// ----------------------------------------------------------------------------
module capt_lexer
  import capt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [CHAR_W-1:0] char_code_i,
  output stack_op_t         op_o,
  output logic              code_next_o
);

  lex_mode_e         mode_q, mode_d;
  logic              bs_q, bs_d;
  logic [CHAR_W-1:0] c;
  logic              esc;
  stack_op_t         op;

  assign c   = (char_code_i == CH_PARA) ? CH_LF : char_code_i;
  assign esc = bs_q;

  always_comb begin
    mode_d = mode_q;
    op     = '0;
    case (mode_q)
      MODE_CODE: begin
        if (c == CH_HASH && !esc) begin
          mode_d = MODE_COMMENT;
        end else if (c == CH_SQUOTE && !esc) begin
          mode_d = MODE_SQ;
        end else if (c == CH_DQUOTE && !esc) begin
          mode_d = MODE_DQ;
        end else if (c == CH_LPAREN) begin
          op.push = 1'b1;
          op.kind = KIND_PAREN;
        end else if (c == CH_LBRACK) begin
          op.push = 1'b1;
          op.kind = KIND_SQUARE;
        end else if (c == CH_LBRACE) begin
          op.push = 1'b1;
          op.kind = KIND_CURLY;
        end else if (c == CH_RPAREN) begin
          op.close = 1'b1;
          op.kind  = KIND_PAREN;
        end else if (c == CH_RBRACK) begin
          op.close = 1'b1;
          op.kind  = KIND_SQUARE;
        end else if (c == CH_RBRACE) begin
          op.close = 1'b1;
          op.kind  = KIND_CURLY;
        end else if (c == CH_COMMA) begin
          op.comma = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_LF && !esc) begin
          mode_d = MODE_CODE;
        end
      end
      MODE_SQ: begin
        if (c == CH_SQUOTE && !esc) begin
          mode_d = MODE_CODE;
        end
      end
      default: begin
        if (c == CH_DQUOTE && !esc) begin
          mode_d = MODE_CODE;
        end
      end
    endcase
    bs_d = (c == CH_BSLASH);
  end

  assign op_o        = accept_i ? op : '0;
  assign code_next_o = (mode_d == MODE_CODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
      bs_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      bs_q   <= bs_d;
    end
  end

endmodule

@@ src/capt_cell.sv @@
// ----------------------------------------------------------------------------
// capt_cell
// One bracket level: open flag, bracket kind and comma count.
// ----------------------------------------------------------------------------
module capt_cell
  import capt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stack_op_t             op_i,
  input  logic                  open_below_i,
  input  cell_link_t            link_i,
  output cell_link_t            link_o,
  output logic                  open_next_o,
  output bracket_kind_e         kind_next_o,
  output logic [COMMA_BITS-1:0] commas_next_o
);

  logic                  open_q, open_d;
  bracket_kind_e         kind_q, kind_d;
  logic [COMMA_BITS-1:0] commas_q, commas_d;

  assign link_o.open  = open_q;
  assign link_o.match = link_i.match | (open_q && kind_q == op_i.kind);

  always_comb begin
    open_d   = open_q;
    kind_d   = kind_q;
    commas_d = commas_q;
    if (op_i.push && open_below_i && !open_q) begin
      open_d   = 1'b1;
      kind_d   = op_i.kind;
      commas_d = '0;
    end
    if (op_i.close) begin
      open_d = open_q && link_i.match;
    end
    if (op_i.comma && open_q && !link_i.open && commas_q != COMMA_MAX) begin
      commas_d = commas_q + 1'b1;
    end
  end

  assign open_next_o   = open_d;
  assign kind_next_o   = kind_d;
  assign commas_next_o = commas_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    commas_q <= commas_d;
  end

endmodule

@@ src/call_argument_position_tracker.sv @@
// A character's result beat is registered and presented in the cycle after it is accepted.
// Throughput: one character per cycle; a stalled result blocks input.
// The bracket stack is a row of cells; a closer resolves in the same cycle.
// Reset clears lexer mode, open levels, outer commas, overflow and the
// argument count; no clearing pass is needed.
// ----------------------------------------------------------------------------
// call_argument_position_tracker
// Tracks the active argument of an open call over a stream of characters.
// ----------------------------------------------------------------------------
module call_argument_position_tracker
  import capt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  capt_char_if.sink          char_i,
  capt_result_if.source      res_o,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i
);

  logic                   accept;
  stack_op_t              op;
  logic                   code_next;
  cell_link_t             link [STACK_DEPTH+1];
  logic [STACK_DEPTH-1:0] open_vec;
  logic [STACK_DEPTH-1:0] open_next;
  bracket_kind_e          kind0_d;
  logic [COMMA_BITS-1:0]  commas0_d;

  logic [COUNT_W-1:0]     arg_count_q;
  logic [COMMA_BITS-1:0]  outer_q, outer_d;
  logic                   ovf_q, ovf_d;
  logic                   res_valid_q;
  logic                   idx_valid_q, idx_valid_d;
  logic [INDEX_W-1:0]     index_q, index_d;

  assign accept       = char_i.valid && char_i.ready;
  assign char_i.ready = !res_valid_q || res_o.ready;

  capt_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_i.char_code),
    .op_o        (op),
    .code_next_o (code_next)
  );

  assign link[STACK_DEPTH] = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    assign open_vec[i] = link[i].open;
    if (i == 0) begin : g_head
      capt_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .op_i          (op),
        .open_below_i  (1'b1),
        .link_i        (link[i+1]),
        .link_o        (link[i]),
        .open_next_o   (open_next[i]),
        .kind_next_o   (kind0_d),
        .commas_next_o (commas0_d)
      );
    end else begin : g_body
      capt_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .op_i          (op),
        .open_below_i  (link[i-1].open),
        .link_i        (link[i+1]),
        .link_o        (link[i]),
        .open_next_o   (open_next[i]),
        .kind_next_o   (),
        .commas_next_o ()
      );
    end
  end

  always_comb begin
    outer_d = outer_q;
    if (op.close && !link[0].match) begin
      outer_d = '0;
    end else if (op.comma && !open_vec[0] && outer_q != COMMA_MAX) begin
      outer_d = outer_q + 1'b1;
    end
    ovf_d = ovf_q | (op.push && open_vec[STACK_DEPTH-1]);

    idx_valid_d = code_next && !ovf_d && open_next[0] && !open_next[1] &&
                  kind0_d == KIND_PAREN && outer_d == '0 &&
                  CMP_W'(commas0_d) < CMP_W'(arg_count_q);
    index_d     = idx_valid_d ? INDEX_W'(commas0_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_count_q <= '0;
      outer_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arg_count_q <= cfg_wdata_i;
      end
      outer_q <= outer_d;
      ovf_q   <= ovf_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_valid_q <= idx_valid_d;
      index_q     <= index_d;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.index_valid      = idx_valid_q;
  assign res_o.argument_index   = index_q;
  assign res_o.stack_overflowed = ovf_q;

  a_open_thermometer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((open_vec + 1'b1) & open_vec) == '0)
    else $error("open levels not contiguous from the bottom");

  a_overflow_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag dropped");

  a_valid_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && idx_valid_q) |-> !ovf_q)
    else $error("index reported valid after overflow");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !idx_valid_q) |-> (index_q == '0))
    else $error("invalid result carries nonzero index");

endmodule

@@ sim/tb_call_argument_position_tracker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_call_argument_position_tracker
// Streams characters through the tracker and predicts each position report
// in step: lexer modes, escapes, the bracket stack, comma saturation and
// overflow. Both channels stall in random bursts; reports are checked in order.
// ----------------------------------------------------------------------------
module tb_call_argument_position_tracker;
  import capt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic               index_valid;
    logic [INDEX_W-1:0] argument_index;
    logic               stack_overflowed;
  } position_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;

  capt_char_if   char_if ();
  capt_result_if res_if ();

  call_argument_position_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  lex_mode_e            scan_mode = MODE_CODE;
  logic                 prev_bslash = 1'b0;
  bracket_kind_e        kind_stack [STACK_DEPTH];
  logic [COMMA_BITS-1:0] level_commas [STACK_DEPTH];
  logic [COMMA_BITS-1:0] outer_commas = '0;
  int unsigned          nest_depth = 0;
  logic                 stack_full_seen = 1'b0;
  logic [COUNT_W-1:0]   hint_count = '0;

  position_t     pending_positions [$];
  bracket_kind_e gen_open [$];
  int unsigned   chars_sent = 0;
  int unsigned   mismatches = 0;
  int unsigned   valid_reports = 0;
  int unsigned   overflow_reports = 0;
  int unsigned   cfg_writes = 0;
  int unsigned   cycle_cnt = 0;
  bit            idling_on = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycle_cnt,
               pending_positions.size());
      $display("tb_call_argument_position_tracker NOT OK");
      $finish;
    end
  end

  function automatic void open_level(bracket_kind_e kind);
    if (nest_depth >= STACK_DEPTH) begin
      stack_full_seen = 1'b1;
    end else begin
      kind_stack[nest_depth] = kind;
      level_commas[nest_depth] = '0;
      nest_depth++;
    end
  endfunction

  function automatic void close_level(bracket_kind_e kind);
    logic hit;
    hit = 1'b0;
    for (int k = nest_depth; k > 0; k--) begin
      if (!hit && kind_stack[k-1] == kind) begin
        nest_depth = k - 1;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      nest_depth = 0;
      outer_commas = '0;
    end
  endfunction

  function automatic position_t predict_position(logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] c;
    logic esc;
    position_t r;
    c = (code == CH_PARA) ? CH_LF : code;
    esc = prev_bslash;
    case (scan_mode)
      MODE_CODE: begin
        if (c == CH_HASH && !esc) scan_mode = MODE_COMMENT;
        else if (c == CH_SQUOTE && !esc) scan_mode = MODE_SQ;
        else if (c == CH_DQUOTE && !esc) scan_mode = MODE_DQ;
        else if (c == CH_LPAREN) open_level(KIND_PAREN);
        else if (c == CH_LBRACK) open_level(KIND_SQUARE);
        else if (c == CH_LBRACE) open_level(KIND_CURLY);
        else if (c == CH_RPAREN) close_level(KIND_PAREN);
        else if (c == CH_RBRACK) close_level(KIND_SQUARE);
        else if (c == CH_RBRACE) close_level(KIND_CURLY);
        else if (c == CH_COMMA) begin
          if (nest_depth > 0) begin
            if (level_commas[nest_depth-1] != COMMA_MAX)
              level_commas[nest_depth-1]++;
          end else if (outer_commas != COMMA_MAX) begin
            outer_commas++;
          end
        end
      end
      MODE_COMMENT: if (c == CH_LF && !esc) scan_mode = MODE_CODE;
      MODE_SQ: if (c == CH_SQUOTE && !esc) scan_mode = MODE_CODE;
      default: if (c == CH_DQUOTE && !esc) scan_mode = MODE_CODE;
    endcase
    prev_bslash = (c == CH_BSLASH);
    r.index_valid = scan_mode == MODE_CODE && !stack_full_seen && nest_depth == 1 &&
                    kind_stack[0] == KIND_PAREN && outer_commas == '0 &&
                    CMP_W'(level_commas[0]) < CMP_W'(hint_count);
    r.argument_index = r.index_valid ? INDEX_W'(level_commas[0]) : '0;
    r.stack_overflowed = stack_full_seen;
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_positions
    position_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (res_if.index_valid) valid_reports++;
      if (res_if.stack_overflowed) overflow_reports++;
      if (pending_positions.size() == 0) begin
        note_mismatch("unexpected beat", 0, 1);
      end else begin
        want = pending_positions.pop_front();
        if (res_if.index_valid !== want.index_valid)
          note_mismatch("index_valid", want.index_valid, res_if.index_valid);
        if (res_if.argument_index !== want.argument_index)
          note_mismatch("argument_index", want.argument_index, res_if.argument_index);
        if (res_if.stack_overflowed !== want.stack_overflowed)
          note_mismatch("stack_overflowed", want.stack_overflowed,
                        res_if.stack_overflowed);
      end
    end
  end

  // result side: stall in bursts
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 17);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] code);
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.char_code <= code;
    do @(posedge clk_i); while (!char_if.ready);
    pending_positions.push_back(predict_position(code));
    chars_sent++;
  endtask

  task automatic drain_reports();
    @(negedge clk_i);
    char_if.valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_hint_count(logic [COUNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    hint_count = value;
    cfg_writes++;
  endtask

  function automatic logic [CHAR_W-1:0] opener_of(bracket_kind_e kind);
    case (kind)
      KIND_PAREN:  return CH_LPAREN;
      KIND_SQUARE: return CH_LBRACK;
      default:     return CH_LBRACE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] closer_of(bracket_kind_e kind);
    case (kind)
      KIND_PAREN:  return CH_RPAREN;
      KIND_SQUARE: return CH_RBRACK;
      default:     return CH_RBRACE;
    endcase
  endfunction

  function automatic bracket_kind_e pick_kind();
    case ($urandom_range(0, 3))
      0: return KIND_SQUARE;
      1: return KIND_CURLY;
      default: return KIND_PAREN;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(16'h20, 16'h7E));
    while (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic send_string_literal();
    logic [CHAR_W-1:0] quote;
    logic [CHAR_W-1:0] esc_c;
    quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    send_char(quote);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: esc_c = CH_SQUOTE;
          1: esc_c = CH_DQUOTE;
          2: esc_c = CH_LF;
          3: esc_c = CH_BSLASH;
          default: esc_c = 16'h006E;
        endcase
        send_char(CH_BSLASH);
        send_char(esc_c);
        if (esc_c == CH_BSLASH) send_char(16'h0078);
      end else begin
        send_char(plain_char());
      end
    end
    send_char(quote);
  endtask

  task automatic send_comment();
    send_char(CH_HASH);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        send_char(CH_BSLASH);
        send_char(CH_LF);
      end else begin
        send_char(plain_char());
      end
    end
    send_char($urandom_range(0, 1) ? CH_LF : CH_PARA);
  endtask

  task automatic send_token(int unsigned max_nest);
    int unsigned r;
    bracket_kind_e kind;
    r = $urandom_range(0, 99);
    if (gen_open.size() == 0 && r < 40) begin
      gen_open.push_back(KIND_PAREN);
      send_char(CH_LPAREN);
    end else if (r < 25) begin
      send_char(CHAR_W'($urandom_range(16'h61, 16'h7A)));
    end else if (r < 34) begin
      send_char(CH_COMMA);
    end else if (r < 42) begin
      if (gen_open.size() < max_nest) begin
        kind = pick_kind();
        gen_open.push_back(kind);
        send_char(opener_of(kind));
      end else begin
        send_char(CH_COMMA);
      end
    end else if (r < 55) begin
      if (gen_open.size() > 0) send_char(closer_of(gen_open.pop_back()));
      else send_char(CHAR_W'($urandom_range(16'h30, 16'h39)));
    end else if (r < 61) begin
      send_char(16'h0020);
    end else if (r < 69) begin
      send_string_literal();
    end else if (r < 74) begin
      send_comment();
    end else if (r < 79) begin
      send_char(CH_LF);
    end else begin
      case ($urandom_range(0, 5))
        0: send_char(CHAR_W'($urandom_range(0, 16'hFFFF)));
        1: begin
          send_char(CH_BSLASH);
          send_char(16'h0071);
        end
        2: send_char(plain_char());
        3: send_char(CH_PARA);
        4: begin
          if (gen_open.size() == 0) send_char(closer_of(pick_kind()));
          else send_char(CHAR_W'($urandom_range(0, 16'hFFFF)));
        end
        default: begin
          // unmatched closer wipes the stack, so the generator follows suit
          if ($urandom_range(0, 3) == 0) begin
            send_char(CH_COMMA);
            gen_open.delete();
            send_char(closer_of(pick_kind()));
          end else begin
            send_char(CHAR_W'($urandom_range(0, 16'hFFFF)));
          end
        end
      endcase
    end
  endtask

  task automatic test_first_opener();
    send_char(CH_LPAREN);
    send_char(CH_COMMA);
    drain_reports();
    write_hint_count(8'd3);
    send_char(16'h0061);
    send_char(CH_COMMA);
    send_char(CH_COMMA);
    send_char(CH_RPAREN);
  endtask

  task automatic test_lexer_skips();
    send_char(CH_LPAREN);
    send_char(CH_HASH);
    send_char(CH_RPAREN);
    send_char(CH_PARA);
    send_char(CH_SQUOTE);
    send_char(CH_BSLASH);
    send_char(CH_SQUOTE);
    send_char(CH_SQUOTE);
    send_char(CH_DQUOTE);
    send_char(CH_BSLASH);
    send_char(CH_BSLASH);
    send_char(CH_DQUOTE);
    send_char(CH_DQUOTE);
    send_char(CH_HASH);
    send_char(CH_BSLASH);
    send_char(CH_LF);
    send_char(CH_LF);
    send_char(16'h0000);
    send_char(16'hFFFF);
    send_char(CH_BSLASH);
    send_char(CH_HASH);
    send_char(CH_COMMA);
  endtask

  task automatic test_unmatched_closer();
    send_char(CH_RPAREN);
    send_char(CH_COMMA);
    send_char(CH_LPAREN);
    send_char(CH_LBRACK);
    send_char(CH_RBRACE);
    send_char(CH_LPAREN);
    send_char(CH_LBRACE);
    send_char(CH_RPAREN);
  endtask

  task automatic test_comma_saturation();
    drain_reports();
    write_hint_count(8'd255);
    send_char(CH_LPAREN);
    repeat (COMMA_MAX + 3) send_char(CH_COMMA);
    send_char(CH_RPAREN);
    repeat (COMMA_MAX + 3) send_char(CH_COMMA);
    send_char(CH_RBRACK);
    send_char(CH_LPAREN);
    send_char(CH_COMMA);
    send_char(CH_RPAREN);
  endtask

  task automatic test_random_phase(logic [COUNT_W-1:0] count, int unsigned n_chars);
    int unsigned stop_at;
    drain_reports();
    write_hint_count(count);
    gen_open.delete();
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at)
      send_token($urandom_range(0, 9) == 0 ? 12 : 5);
  endtask

  task automatic test_stack_overflow();
    drain_reports();
    write_hint_count(8'd2);
    send_char(CH_RBRACE);
    repeat (STACK_DEPTH + 2) send_char(CH_LPAREN);
    send_char(CH_RPAREN);
    send_char(CH_COMMA);
    send_char(CH_RBRACK);
    send_char(CH_LPAREN);
    gen_open.delete();
    repeat (40) send_token(5);
  endtask

  initial begin
    rst_ni = 1'b0;
    char_if.valid = 1'b0;
    char_if.char_code = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_first_opener();
    test_lexer_skips();
    test_unmatched_closer();
    test_comma_saturation();

    idling_on = 1'b1;
    test_random_phase(8'd4, 70);
    test_random_phase(8'd1, 60);
    test_random_phase(8'd0, 50);
    test_random_phase(8'd6, 70);
    test_random_phase(COUNT_W'($urandom_range(0, 255)), 60);
    test_random_phase(8'd255, 60);
    test_random_phase(8'd3, 60);

    idling_on = 1'b0;
    test_random_phase(8'd4, 70);
    test_stack_overflow();

    drain_reports();
    repeat (5) @(posedge clk_i);
    $display("Covered %0d characters, %0d argument-count writes, %0d valid reports,",
             chars_sent, cfg_writes, valid_reports);
    $display("%0d reports after stack overflow, %0d mismatches.", overflow_reports,
             mismatches);
    if (mismatches == 0 && pending_positions.size() == 0) begin
      $display("tb_call_argument_position_tracker OK");
    end else begin
      $display("tb_call_argument_position_tracker NOT OK");
    end
    $finish;
  end

endmodule
